>>> rtl/core/hicr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hicr_pkg
// Shared types and constants for the chained hash table with replacement.
// ----------------------------------------------------------------------------
package hicr_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int KEY_W     = 32;
    localparam int SIZE_W    = 7;
    localparam int BIT_CNT_W = $clog2(KEY_W);

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_SLOTS);
    localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(MAX_SLOTS);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_READ     = 2'd2;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] placed_slot;
        logic              read_valid;
        logic [KEY_W-1:0]  read_key;
        logic [LINK_W-1:0] read_link;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  num;
        logic [SIZE_W-1:0] den;
    } t_mod_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RD_WAIT,
        S_HASH,
        S_HOME,
        S_PROBE,
        S_VRD,
        S_VWAIT,
        S_VHASH,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_PRED_RD,
        S_PRED_CHK,
        S_W1,
        S_W2,
        S_W3
    } t_state;

endpackage

>>> rtl/core/hicr_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hicr_mod
// Bit-serial remainder unit: one restoring step per cycle over the key bits.
// ----------------------------------------------------------------------------
module hicr_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hicr_pkg::t_mod_req         i_req,
    output logic                       o_done,
    output logic [hicr_pkg::SLOT_W-1:0] o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [hicr_pkg::BIT_CNT_W-1:0] r_cnt;
    logic [hicr_pkg::KEY_W-1:0]    r_num;
    logic [hicr_pkg::SLOT_W-1:0]   r_rem;
    logic [hicr_pkg::SIZE_W-1:0]   r_den;
    logic [hicr_pkg::SIZE_W-1:0]   n_trial;
    logic [hicr_pkg::SIZE_W-1:0]   n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[hicr_pkg::KEY_W-1]};
        if (n_trial >= r_den) begin
            n_rem = n_trial - r_den;
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hicr_pkg::BIT_CNT_W'(hicr_pkg::KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[hicr_pkg::KEY_W-2:0], 1'b0};
            r_rem <= n_rem[hicr_pkg::SLOT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/hash_insert_chain_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_insert_chain_replace
// Hash table of keys and links, chaining with replacement, one transaction
// at a time.
// ----------------------------------------------------------------------------
// Read: the addressed slot is read in S_RD and returned in S_RD_WAIT.
// Insert: the key is hashed by the serial remainder unit and stored in a
// free home slot; on a collision later slots are probed for a free one,
// the resident key's home is hashed, a chain is walked via the single read
// port of the slot memories, and S_W1..S_W3 write. One transaction in flight.
// Reset clears all used bits (table empty) and sets table_size to 64.
module hash_insert_chain_replace (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hicr_pkg::t_in       i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hicr_pkg::t_out      o_out,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data
);

    localparam int SW = hicr_pkg::SLOT_W;
    localparam int LW = hicr_pkg::LINK_W;
    localparam int KW = hicr_pkg::KEY_W;
    localparam int ZW = hicr_pkg::SIZE_W;

    hicr_pkg::t_state r_state, n_state;

    logic [KW-1:0] mem_key  [hicr_pkg::MAX_SLOTS];
    logic [LW-1:0] mem_link [hicr_pkg::MAX_SLOTS];
    logic [KW-1:0] r_key_rd;
    logic [LW-1:0] r_link_rd;
    logic [hicr_pkg::MAX_SLOTS-1:0] r_used;

    logic [ZW-1:0] r_table_size;
    logic [ZW-1:0] size_eff;

    logic [KW-1:0] r_key;
    logic [KW-1:0] r_vkey;
    logic [LW-1:0] r_vlink;
    logic [SW-1:0] r_h;
    logic [SW-1:0] r_f;
    logic [SW-1:0] r_s;
    logic [SW-1:0] r_p;
    logic [ZW-1:0] r_cnt;
    logic [SW-1:0] r_steps;
    logic          r_chain;
    logic          r_pfound;

    logic              r_out_valid;
    hicr_pkg::t_out    r_out;

    logic              accept;
    logic              link_ok;
    logic [SW-1:0]     link_slot;
    logic [ZW-1:0]     h_inc;
    logic [ZW-1:0]     s_inc;
    logic              mod_done;
    logic [SW-1:0]     mod_rem;
    hicr_pkg::t_mod_req mod_req;

    logic          key_we, link_we, used_set, out_load;
    logic [SW-1:0] key_waddr, link_waddr, used_addr;
    logic [KW-1:0] key_wdata;
    logic [LW-1:0] link_wdata;
    hicr_pkg::t_out n_out;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != hicr_pkg::S_IDLE) || r_out_valid;
    assign link_slot  = r_link_rd[SW-1:0];
    assign link_ok    = !r_link_rd[LW-1] && r_used[link_slot];
    assign h_inc      = {1'b0, r_h} + 1'b1;
    assign s_inc      = {1'b0, r_s} + 1'b1;

    always_comb begin
        if (r_table_size == '0) begin
            size_eff = ZW'(1);
        end else if (r_table_size > hicr_pkg::SIZE_RST) begin
            size_eff = hicr_pkg::SIZE_RST;
        end else begin
            size_eff = r_table_size;
        end
    end

    hicr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hicr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_in.op == hicr_pkg::OP_READ) ? hicr_pkg::S_RD
                                                             : hicr_pkg::S_HASH;
                end
            end
            hicr_pkg::S_RD:      n_state = hicr_pkg::S_RD_WAIT;
            hicr_pkg::S_RD_WAIT: n_state = hicr_pkg::S_IDLE;
            hicr_pkg::S_HASH: begin
                if (mod_done) n_state = hicr_pkg::S_HOME;
            end
            hicr_pkg::S_HOME: begin
                if (!r_used[r_h] || size_eff == ZW'(1)) begin
                    n_state = hicr_pkg::S_IDLE;
                end else begin
                    n_state = hicr_pkg::S_PROBE;
                end
            end
            hicr_pkg::S_PROBE: begin
                if (!r_used[r_s]) begin
                    n_state = hicr_pkg::S_VRD;
                end else if (r_cnt == size_eff - 1'b1) begin
                    n_state = hicr_pkg::S_IDLE;
                end
            end
            hicr_pkg::S_VRD:   n_state = hicr_pkg::S_VWAIT;
            hicr_pkg::S_VWAIT: n_state = hicr_pkg::S_VHASH;
            hicr_pkg::S_VHASH: begin
                if (mod_done) begin
                    n_state = (mod_rem == r_h) ? hicr_pkg::S_TAIL_RD
                                               : hicr_pkg::S_PRED_RD;
                end
            end
            hicr_pkg::S_TAIL_RD: n_state = hicr_pkg::S_TAIL_CHK;
            hicr_pkg::S_TAIL_CHK: begin
                if (!link_ok || r_steps == SW'(hicr_pkg::MAX_SLOTS - 1)) begin
                    n_state = hicr_pkg::S_W1;
                end else begin
                    n_state = hicr_pkg::S_TAIL_RD;
                end
            end
            hicr_pkg::S_PRED_RD: begin
                n_state = r_used[r_s] ? hicr_pkg::S_PRED_CHK : hicr_pkg::S_W1;
            end
            hicr_pkg::S_PRED_CHK: begin
                if (!link_ok || link_slot == r_h
                    || r_steps == SW'(hicr_pkg::MAX_SLOTS - 1)) begin
                    n_state = hicr_pkg::S_W1;
                end else begin
                    n_state = hicr_pkg::S_PRED_RD;
                end
            end
            hicr_pkg::S_W1: n_state = hicr_pkg::S_W2;
            hicr_pkg::S_W2: n_state = r_chain ? hicr_pkg::S_IDLE : hicr_pkg::S_W3;
            hicr_pkg::S_W3: n_state = hicr_pkg::S_IDLE;
            default:        n_state = hicr_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        key_we     = 1'b0;
        link_we    = 1'b0;
        used_set   = 1'b0;
        out_load   = 1'b0;
        key_waddr  = r_f;
        link_waddr = r_f;
        used_addr  = r_f;
        key_wdata  = r_key;
        link_wdata = hicr_pkg::LINK_NONE;
        n_out      = '0;
        mod_req.start = 1'b0;
        mod_req.num   = r_key_rd;
        mod_req.den   = size_eff;
        case (r_state)
            hicr_pkg::S_IDLE: begin
                mod_req.num   = i_in.key;
                mod_req.start = accept && (i_in.op == hicr_pkg::OP_INSERT);
            end
            hicr_pkg::S_RD_WAIT: begin
                out_load     = 1'b1;
                n_out.status = hicr_pkg::ST_READ;
                if (r_used[r_s]) begin
                    n_out.read_valid = 1'b1;
                    n_out.read_key   = r_key_rd;
                    n_out.read_link  = r_link_rd;
                end else begin
                    n_out.read_link  = hicr_pkg::LINK_NONE;
                end
            end
            hicr_pkg::S_HOME: begin
                if (!r_used[r_h]) begin
                    key_we     = 1'b1;
                    link_we    = 1'b1;
                    used_set   = 1'b1;
                    key_waddr  = r_h;
                    link_waddr = r_h;
                    used_addr  = r_h;
                    out_load   = 1'b1;
                    n_out.status      = hicr_pkg::ST_INSERTED;
                    n_out.placed_slot = r_h;
                end else if (size_eff == ZW'(1)) begin
                    out_load     = 1'b1;
                    n_out.status = hicr_pkg::ST_FULL;
                end
            end
            hicr_pkg::S_PROBE: begin
                if (r_used[r_s] && r_cnt == size_eff - 1'b1) begin
                    out_load     = 1'b1;
                    n_out.status = hicr_pkg::ST_FULL;
                end
            end
            hicr_pkg::S_VWAIT: begin
                mod_req.start = 1'b1;
            end
            hicr_pkg::S_W1: begin
                key_we     = 1'b1;
                link_we    = 1'b1;
                used_set   = 1'b1;
                key_wdata  = r_chain ? r_key : r_vkey;
                link_wdata = r_chain ? hicr_pkg::LINK_NONE : r_vlink;
            end
            hicr_pkg::S_W2: begin
                link_we    = r_chain || r_pfound;
                link_waddr = r_p;
                link_wdata = {1'b0, r_f};
                if (r_chain) begin
                    out_load = 1'b1;
                    n_out.status      = hicr_pkg::ST_INSERTED;
                    n_out.placed_slot = r_f;
                end
            end
            hicr_pkg::S_W3: begin
                key_we     = 1'b1;
                link_we    = 1'b1;
                key_waddr  = r_h;
                link_waddr = r_h;
                out_load   = 1'b1;
                n_out.status      = hicr_pkg::ST_INSERTED;
                n_out.placed_slot = r_h;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we)  mem_key[key_waddr]   <= key_wdata;
        if (link_we) mem_link[link_waddr] <= link_wdata;
        r_key_rd  <= mem_key[r_s];
        r_link_rd <= mem_link[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hicr_pkg::S_IDLE;
            r_used       <= '0;
            r_table_size <= hicr_pkg::SIZE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (used_set) r_used[used_addr] <= 1'b1;
            if (i_cfg_we) r_table_size <= i_cfg_data;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= n_out;
        case (r_state)
            hicr_pkg::S_IDLE: begin
                r_key <= i_in.key;
                r_s   <= i_in.slot_index;
            end
            hicr_pkg::S_HASH: begin
                r_h <= mod_rem;
            end
            hicr_pkg::S_HOME: begin
                r_cnt <= ZW'(1);
                r_s   <= (h_inc == size_eff) ? '0 : h_inc[SW-1:0];
            end
            hicr_pkg::S_PROBE: begin
                if (!r_used[r_s]) begin
                    r_f <= r_s;
                    r_s <= r_h;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_s   <= (s_inc == size_eff) ? '0 : s_inc[SW-1:0];
                end
            end
            hicr_pkg::S_VWAIT: begin
                r_vkey  <= r_key_rd;
                r_vlink <= r_link_rd;
            end
            hicr_pkg::S_VHASH: begin
                r_steps  <= '0;
                r_pfound <= 1'b0;
                r_chain  <= (mod_rem == r_h);
                r_s      <= (mod_rem == r_h) ? r_h : mod_rem;
            end
            hicr_pkg::S_TAIL_CHK: begin
                if (!link_ok) begin
                    r_p <= r_s;
                end else begin
                    r_p     <= link_slot;
                    r_s     <= link_slot;
                    r_steps <= r_steps + 1'b1;
                end
            end
            hicr_pkg::S_PRED_CHK: begin
                if (link_ok && link_slot == r_h) begin
                    r_p      <= r_s;
                    r_pfound <= 1'b1;
                end else if (link_ok) begin
                    r_s     <= link_slot;
                    r_steps <= r_steps + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/hicr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hicr_checker
// Port-level assertions for the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module hicr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input hicr_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while one is in flight");

    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("transaction taken while a result waits");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == hicr_pkg::ST_READ && !o_out.read_valid
        |-> o_out.read_link == hicr_pkg::LINK_NONE && o_out.read_key == '0)
        else $error("empty slot read with nonzero fields");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == hicr_pkg::ST_FULL |-> o_out.placed_slot == '0)
        else $error("full status with nonzero slot");

endmodule

bind hash_insert_chain_replace hicr_checker u_hicr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
